>>> rtl/gbns_pkg.sv
`timescale 1ns / 1ps
package gbns_pkg;

  // Command opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PATH     = 2'd0;
  localparam logic [1:0] ST_ADJACENT = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;
  localparam logic [1:0] ST_UNREACH  = 2'd3;

  // Probe directions: x-1, x+1, y+1, y-1
  localparam logic [1:0] DIR_XM = 2'd0;
  localparam logic [1:0] DIR_XP = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef struct packed {
    logic       op;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic       cell_blocked;
    logic [4:0] start_x;
    logic [4:0] start_y;
    logic [4:0] target_x;
    logic [4:0] target_y;
  } in_t;

  typedef struct packed {
    logic [4:0] next_x;
    logic [4:0] next_y;
    logic [1:0] status;
  } out_t;

  // Write controls for the cell memories
  typedef struct packed {
    logic       occ_we;
    logic       occ_wd;
    logic       vis_we;
    logic       vis_wd;
    logic       par_we;
    logic [1:0] par_wd;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SEED, S_POP, S_CUR, S_PROBE_RD, S_PROBE_CHK,
    S_TRACE_RD, S_TRACE_CHK, S_FB_RD, S_FB_CHK, S_FINAL
  } state_t;

  // Fallback order: +x, +y, -x, -y
  function automatic logic [1:0] fb_dir(input logic [1:0] i);
    logic [1:0] d;
    unique case (i)
      2'd0: d = DIR_XP;
      2'd1: d = DIR_YP;
      2'd2: d = DIR_XM;
      default: d = DIR_YM;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/gbns_cellmem.sv
`timescale 1ns / 1ps
module gbns_cellmem #(
  parameter int GRID_DIM = 32
) (
  input  logic                                  clk,
  input  logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  addr,
  input  gbns_pkg::cell_ctl_t                   ctl,
  output logic                                  occ_q,
  output logic                                  vis_q,
  output logic [1:0]                            par_q
);
  localparam int N = GRID_DIM * GRID_DIM;

  logic       occ_mem [N];
  logic       vis_mem [N];
  logic [1:0] par_mem [N];

  // Occupancy: read-before-write, one port
  always_ff @(posedge clk) begin
    if (ctl.occ_we) begin
      occ_mem[addr] <= ctl.occ_wd;
    end
    occ_q <= occ_mem[addr];
  end

  // Visited marks
  always_ff @(posedge clk) begin
    if (ctl.vis_we) begin
      vis_mem[addr] <= ctl.vis_wd;
    end
    vis_q <= vis_mem[addr];
  end

  // Parent directions
  always_ff @(posedge clk) begin
    if (ctl.par_we) begin
      par_mem[addr] <= ctl.par_wd;
    end
    par_q <= par_mem[addr];
  end

endmodule

>>> rtl/gbns_queue.sv
`timescale 1ns / 1ps
module gbns_queue #(
  parameter int GRID_DIM = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  waddr,
  input  logic [2*$clog2(GRID_DIM)-1:0]         wdata,
  input  logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  raddr,
  output logic [2*$clog2(GRID_DIM)-1:0]         rdata
);
  localparam int N  = GRID_DIM * GRID_DIM;
  localparam int EW = 2 * $clog2(GRID_DIM);

  logic [EW-1:0] mem [N];

  // Frontier storage: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/grid_bfs_next_step_unit.sv
`timescale 1ns / 1ps
// Next-tile chooser on a GRID_DIM x GRID_DIM occupancy grid. A write command
// (op 0) updates one cell in the cycle it is accepted and produces no result.
// A query (op 1) frees the start cell, clears the visited marks in one pass
// over all GRID_DIM*GRID_DIM cells, then runs a breadth-first search that pops
// and reads each dequeued cell and probes each neighbour with a read and a
// check state (an off-grid probe skips the check), and finally walks the parent
// chain back with a read and a check state per step. All probes share the
// single-port cell memory. A query with the start off the grid answers in the
// next cycle. After reset the block sweeps the occupancy memory with busy high.
// The result appears for one cycle with done high and cannot be stalled; busy
// is already low then.
module grid_bfs_next_step_unit #(
  parameter int GRID_DIM = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gbns_pkg::in_t  cmd,
  output logic           done,
  output gbns_pkg::out_t result
);
  localparam int N  = GRID_DIM * GRID_DIM;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(GRID_DIM);

  gbns_pkg::state_t state, state_next;

  logic [IW-1:0] cnt, cnt_next;
  logic [IW:0]   head, head_next, tail, tail_next;
  logic [CW-1:0] sx, sy, tx, ty, cx, cy, fx, fy;
  logic [CW-1:0] sx_next, sy_next, tx_next, ty_next, cx_next, cy_next;
  logic [CW-1:0] fx_next, fy_next;
  logic          t_in, t_in_next, first, first_next;
  logic [1:0]    d, d_next, fi, fi_next, st, st_next;
  logic          done_next;
  gbns_pkg::out_t result_next;

  logic [IW-1:0]     addr;
  gbns_pkg::cell_ctl_t ctl;
  logic              occ_q, vis_q;
  logic [1:0]        par_q;
  logic              q_we;
  logic [2*CW-1:0]   q_wdata, q_rdata;
  logic [CW-1:0]     qx, qy;

  logic          accept, s_in, c_in;
  logic [1:0]    nb_dir;
  logic          nb_ok;
  logic [CW-1:0] nbx, nby, px, py;

  function automatic logic [IW-1:0] cidx(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return IW'(IW'(y) * IW'(GRID_DIM) + IW'(x));
  endfunction

  gbns_cellmem #(.GRID_DIM(GRID_DIM)) u_cellmem (
    .clk  (clk),
    .addr (addr),
    .ctl  (ctl),
    .occ_q(occ_q),
    .vis_q(vis_q),
    .par_q(par_q)
  );

  gbns_queue #(.GRID_DIM(GRID_DIM)) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(tail[IW-1:0]),
    .wdata(q_wdata),
    .raddr(head[IW-1:0]),
    .rdata(q_rdata)
  );

  assign busy   = (state != gbns_pkg::S_IDLE);
  assign accept = start && !busy;
  assign s_in   = (int'(cmd.start_x) < GRID_DIM) && (int'(cmd.start_y) < GRID_DIM);
  assign c_in   = (int'(cmd.cell_x) < GRID_DIM) && (int'(cmd.cell_y) < GRID_DIM);
  assign qx     = q_rdata[2*CW-1:CW];
  assign qy     = q_rdata[CW-1:0];

  // Neighbour of the current cell in the probe or fallback direction
  always_comb begin
    nb_dir = (state == gbns_pkg::S_FB_RD || state == gbns_pkg::S_FB_CHK) ?
             gbns_pkg::fb_dir(fi) : d;
    nbx   = cx;
    nby   = cy;
    nb_ok = 1'b1;
    unique case (nb_dir)
      gbns_pkg::DIR_XM: begin
        nb_ok = (cx != '0);
        nbx   = cx - CW'(1);
      end
      gbns_pkg::DIR_XP: begin
        nb_ok = (cx != CW'(GRID_DIM - 1));
        nbx   = cx + CW'(1);
      end
      gbns_pkg::DIR_YP: begin
        nb_ok = (cy != CW'(GRID_DIM - 1));
        nby   = cy + CW'(1);
      end
      default: begin
        nb_ok = (cy != '0);
        nby   = cy - CW'(1);
      end
    endcase
  end

  // Parent of the current cell: step back against its parent direction
  always_comb begin
    px = cx;
    py = cy;
    unique case (par_q)
      gbns_pkg::DIR_XM: px = cx + CW'(1);
      gbns_pkg::DIR_XP: px = cx - CW'(1);
      gbns_pkg::DIR_YP: py = cy - CW'(1);
      default:          py = cy + CW'(1);
    endcase
  end

  // Hold state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbns_pkg::S_INIT;
      cnt   <= '0;
      done  <= 1'b0;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    sx     <= sx_next;
    sy     <= sy_next;
    tx     <= tx_next;
    ty     <= ty_next;
    t_in   <= t_in_next;
    cx     <= cx_next;
    cy     <= cy_next;
    fx     <= fx_next;
    fy     <= fy_next;
    st     <= st_next;
    d      <= d_next;
    fi     <= fi_next;
    first  <= first_next;
    result <= result_next;
  end

  // Sequence the search
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    head_next   = head;
    tail_next   = tail;
    sx_next     = sx;
    sy_next     = sy;
    tx_next     = tx;
    ty_next     = ty;
    t_in_next   = t_in;
    cx_next     = cx;
    cy_next     = cy;
    fx_next     = fx;
    fy_next     = fy;
    st_next     = st;
    d_next      = d;
    fi_next     = fi;
    first_next  = first;
    done_next   = 1'b0;
    result_next = result;
    addr        = cidx(cx, cy);
    ctl         = '0;
    q_we        = 1'b0;
    q_wdata     = {nbx, nby};

    unique case (state)
      gbns_pkg::S_INIT: begin
        addr       = cnt;
        ctl.occ_we = 1'b1;
        cnt_next   = cnt + IW'(1);
        if (cnt == IW'(N - 1)) begin
          state_next = gbns_pkg::S_IDLE;
        end
      end
      gbns_pkg::S_IDLE: begin
        if (accept && cmd.op == gbns_pkg::OP_WRITE) begin
          addr       = cidx(CW'(cmd.cell_x), CW'(cmd.cell_y));
          ctl.occ_we = c_in;
          ctl.occ_wd = cmd.cell_blocked;
        end else if (accept && !s_in) begin
          result_next = '{next_x: cmd.start_x, next_y: cmd.start_y,
                          status: gbns_pkg::ST_UNREACH};
          done_next   = 1'b1;
        end else if (accept) begin
          addr       = cidx(CW'(cmd.start_x), CW'(cmd.start_y));
          ctl.occ_we = 1'b1;
          sx_next    = CW'(cmd.start_x);
          sy_next    = CW'(cmd.start_y);
          tx_next    = CW'(cmd.target_x);
          ty_next    = CW'(cmd.target_y);
          t_in_next  = (int'(cmd.target_x) < GRID_DIM) && (int'(cmd.target_y) < GRID_DIM);
          cnt_next   = '0;
          head_next  = '0;
          tail_next  = '0;
          state_next = gbns_pkg::S_CLEAR;
        end
      end
      gbns_pkg::S_CLEAR: begin
        addr       = cnt;
        ctl.vis_we = 1'b1;
        cnt_next   = cnt + IW'(1);
        if (cnt == IW'(N - 1)) begin
          state_next = gbns_pkg::S_SEED;
        end
      end
      gbns_pkg::S_SEED: begin
        addr       = cidx(sx, sy);
        ctl.vis_we = 1'b1;
        ctl.vis_wd = 1'b1;
        q_we       = 1'b1;
        q_wdata    = {sx, sy};
        tail_next  = tail + (IW + 1)'(1);
        state_next = gbns_pkg::S_POP;
      end
      gbns_pkg::S_POP: begin
        if (head == tail) begin
          fx_next    = sx;
          fy_next    = sy;
          st_next    = gbns_pkg::ST_UNREACH;
          state_next = gbns_pkg::S_FINAL;
        end else begin
          head_next  = head + (IW + 1)'(1);
          state_next = gbns_pkg::S_CUR;
        end
      end
      gbns_pkg::S_CUR: begin
        cx_next = qx;
        cy_next = qy;
        if (t_in && qx == tx && qy == ty) begin
          if (qx == sx && qy == sy) begin
            fi_next    = '0;
            state_next = gbns_pkg::S_FB_RD;
          end else begin
            first_next = 1'b1;
            state_next = gbns_pkg::S_TRACE_RD;
          end
        end else begin
          d_next     = gbns_pkg::DIR_XM;
          state_next = gbns_pkg::S_PROBE_RD;
        end
      end
      gbns_pkg::S_PROBE_RD: begin
        addr = cidx(nbx, nby);
        if (nb_ok) begin
          state_next = gbns_pkg::S_PROBE_CHK;
        end else if (d == gbns_pkg::DIR_YM) begin
          state_next = gbns_pkg::S_POP;
        end else begin
          d_next = d + 2'd1;
        end
      end
      gbns_pkg::S_PROBE_CHK: begin
        addr = cidx(nbx, nby);
        if (!(occ_q || vis_q)) begin
          ctl.vis_we = 1'b1;
          ctl.vis_wd = 1'b1;
          ctl.par_we = 1'b1;
          ctl.par_wd = d;
          q_we       = 1'b1;
          tail_next  = tail + (IW + 1)'(1);
        end
        if (d == gbns_pkg::DIR_YM) begin
          state_next = gbns_pkg::S_POP;
        end else begin
          d_next     = d + 2'd1;
          state_next = gbns_pkg::S_PROBE_RD;
        end
      end
      gbns_pkg::S_TRACE_RD: begin
        state_next = gbns_pkg::S_TRACE_CHK;
      end
      gbns_pkg::S_TRACE_CHK: begin
        if (px == sx && py == sy) begin
          if (first) begin
            cx_next    = sx;
            cy_next    = sy;
            fi_next    = '0;
            state_next = gbns_pkg::S_FB_RD;
          end else begin
            fx_next    = cx;
            fy_next    = cy;
            st_next    = gbns_pkg::ST_PATH;
            state_next = gbns_pkg::S_FINAL;
          end
        end else begin
          cx_next    = px;
          cy_next    = py;
          first_next = 1'b0;
          state_next = gbns_pkg::S_TRACE_RD;
        end
      end
      gbns_pkg::S_FB_RD: begin
        addr = cidx(nbx, nby);
        if (nb_ok) begin
          state_next = gbns_pkg::S_FB_CHK;
        end else if (fi == 2'd3) begin
          fx_next    = sx;
          fy_next    = sy;
          st_next    = gbns_pkg::ST_NO_FREE;
          state_next = gbns_pkg::S_FINAL;
        end else begin
          fi_next = fi + 2'd1;
        end
      end
      gbns_pkg::S_FB_CHK: begin
        if (!occ_q) begin
          fx_next    = nbx;
          fy_next    = nby;
          st_next    = gbns_pkg::ST_ADJACENT;
          state_next = gbns_pkg::S_FINAL;
        end else if (fi == 2'd3) begin
          fx_next    = sx;
          fy_next    = sy;
          st_next    = gbns_pkg::ST_NO_FREE;
          state_next = gbns_pkg::S_FINAL;
        end else begin
          fi_next    = fi + 2'd1;
          state_next = gbns_pkg::S_FB_RD;
        end
      end
      gbns_pkg::S_FINAL: begin
        addr        = cidx(fx, fy);
        ctl.occ_we  = 1'b1;
        ctl.occ_wd  = 1'b1;
        result_next = '{next_x: 5'(fx), next_y: 5'(fy), status: st};
        done_next   = 1'b1;
        state_next  = gbns_pkg::S_IDLE;
      end
      default: begin
        state_next = gbns_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/gbns_check.sv
`timescale 1ns / 1ps
module gbns_check #(
  parameter int GRID_DIM = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input gbns_pkg::in_t  cmd,
  input logic           done,
  input gbns_pkg::out_t result
);
  logic acc_wr, acc_qry_in, acc_qry_out;

  assign acc_wr      = start && !busy && cmd.op == gbns_pkg::OP_WRITE;
  assign acc_qry_in  = start && !busy && cmd.op == gbns_pkg::OP_QUERY &&
                       (int'(cmd.start_x) < GRID_DIM) && (int'(cmd.start_y) < GRID_DIM);
  assign acc_qry_out = start && !busy && cmd.op == gbns_pkg::OP_QUERY &&
                       !((int'(cmd.start_x) < GRID_DIM) && (int'(cmd.start_y) < GRID_DIM));

  // A result never lasts longer than one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // The block is ready again whenever a result shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy while result shown");

  // A write transaction completes at once and yields no result
  a_write: assert property (@(posedge clk) disable iff (rst) acc_wr |=> !busy && !done)
    else $error("write transaction misbehaved");

  // An in-grid query starts a search and cannot answer in the next cycle
  a_query: assert property (@(posedge clk) disable iff (rst) acc_qry_in |=> busy && !done)
    else $error("query did not start a search");

  // An off-grid start answers next cycle as unreachable, with the start x
  a_offgrid: assert property (@(posedge clk) disable iff (rst)
    acc_qry_out |=> done && result.status == gbns_pkg::ST_UNREACH &&
                    result.next_x == $past(cmd.start_x))
    else $error("off-grid query answered wrongly");

endmodule

bind grid_bfs_next_step_unit gbns_check #(.GRID_DIM(GRID_DIM)) u_gbns_check (.*);

>>> tb/grid_bfs_next_step_unit_tb.sv
`timescale 1ns / 1ps
module grid_bfs_next_step_unit_tb;

  localparam int DIM = 32;
  localparam int CELLS = DIM * DIM;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    gbns_pkg::in_t cmd;
    int  gap;
    bit  drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  gbns_pkg::in_t  cmd = '0;
  logic done;
  gbns_pkg::out_t result;

  grid_bfs_next_step_unit #(.GRID_DIM(DIM)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block's grid and search scratch state
  bit       occ [CELLS];
  bit       seen [CELLS];
  bit [1:0] came_from [CELLS];
  int       frontier [CELLS];

  pending_t pending[$];
  gbns_pkg::out_t next_steps[$];
  logic     took = 1'b0;
  int       gap_left = 0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       n_writes = 0;
  int       n_queries = 0;
  int       n_status [4] = '{0, 0, 0, 0};

  // Move one cell in a probe direction; report whether it stays on the grid
  function automatic bit move_cell(input int x, input int y, input logic [1:0] d,
                                   output int nx, output int ny);
    nx = x + (d == gbns_pkg::DIR_XM ? -1 : (d == gbns_pkg::DIR_XP ? 1 : 0));
    ny = y + (d == gbns_pkg::DIR_YM ? -1 : (d == gbns_pkg::DIR_YP ? 1 : 0));
    return nx >= 0 && nx < DIM && ny >= 0 && ny < DIM;
  endfunction

  // Run the search for one query and update the grid mirror
  function automatic gbns_pkg::out_t next_step_for(input gbns_pkg::in_t q);
    int sx, sy, tx, ty, fx, fy, s, c, p, head, tail, found, nx, ny, n, i, g;
    logic [1:0] st;
    logic [1:0] fb [4];
    gbns_pkg::out_t r;
    fb = '{gbns_pkg::DIR_XP, gbns_pkg::DIR_YP, gbns_pkg::DIR_XM, gbns_pkg::DIR_YM};
    sx = q.start_x; sy = q.start_y; tx = q.target_x; ty = q.target_y;
    fx = sx; fy = sy; st = gbns_pkg::ST_UNREACH;
    s = sy * DIM + sx;
    occ[s] = 1'b0;
    for (i = 0; i < CELLS; i++) seen[i] = occ[i];
    seen[s] = 1'b1;
    head = 0; tail = 0; found = -1;
    frontier[tail++] = s;
    while (head < tail) begin
      c = frontier[head++];
      if (c % DIM == tx && c / DIM == ty) begin
        found = c;
        break;
      end
      for (i = 0; i < 4; i++) begin
        if (!move_cell(c % DIM, c / DIM, 2'(i), nx, ny)) continue;
        n = ny * DIM + nx;
        if (seen[n]) continue;
        seen[n] = 1'b1;
        came_from[n] = 2'(i);
        if (tail < CELLS) frontier[tail++] = n;
      end
    end
    if (found >= 0) begin
      p = -1;
      if (found != s) begin
        void'(move_cell(found % DIM, found / DIM, came_from[found] ^ 2'd1, nx, ny));
        p = ny * DIM + nx;
      end
      if (found == s || p == s) begin
        // Target at or next to the start: take the first free neighbor
        st = gbns_pkg::ST_NO_FREE;
        for (i = 0; i < 4; i++) begin
          if (move_cell(sx, sy, fb[i], nx, ny) && !occ[ny * DIM + nx]) begin
            fx = nx; fy = ny; st = gbns_pkg::ST_ADJACENT;
            break;
          end
        end
      end else begin
        // Walk back to the cell next to the start
        c = found;
        for (g = 0; g < CELLS; g++) begin
          if (!move_cell(c % DIM, c / DIM, came_from[c] ^ 2'd1, nx, ny)) break;
          p = ny * DIM + nx;
          if (p == s) begin
            fx = c % DIM; fy = c / DIM; st = gbns_pkg::ST_PATH;
            break;
          end
          c = p;
        end
      end
    end
    occ[fy * DIM + fx] = 1'b1;
    r.next_x = 5'(fx);
    r.next_y = 5'(fy);
    r.status = st;
    return r;
  endfunction

  // Sample handshakes, predict on accepted transactions, check results
  always @(posedge clk) begin
    gbns_pkg::out_t exp_r;
    took <= start && !busy && !rst;
    if (!rst && start && !busy) begin
      if (cmd.op == gbns_pkg::OP_WRITE) begin
        occ[cmd.cell_y * DIM + cmd.cell_x] = cmd.cell_blocked;
        n_writes++;
      end else begin
        next_steps.push_back(next_step_for(cmd));
        n_queries++;
      end
    end
    if (!rst && done) begin
      if (next_steps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", result);
      end else begin
        exp_r = next_steps.pop_front();
        n_status[exp_r.status]++;
        if (result.next_x !== exp_r.next_x || result.next_y !== exp_r.next_y ||
            result.status !== exp_r.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                     exp_r.next_x, exp_r.next_y, exp_r.status,
                     result.next_x, result.next_y, result.status);
        end
      end
    end
    // Watchdog on cycles with no transaction in either direction
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present pending transactions at the falling edge
  always @(negedge clk) begin
    pending_t it;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].drain && next_steps.size() != 0)) begin
        start <= 1'b0;
      end else begin
        it = pending.pop_front();
        cmd <= it.cmd;
        start <= 1'b1;
        gap_left = it.gap;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  task automatic add_write(input int x, input int y, input bit blk, input int gap);
    pending_t it;
    it.cmd = gbns_pkg::in_t'($urandom());
    it.cmd.op = gbns_pkg::OP_WRITE;
    it.cmd.cell_x = 5'(x);
    it.cmd.cell_y = 5'(y);
    it.cmd.cell_blocked = blk;
    it.gap = gap;
    it.drain = 1'b0;
    pending.push_back(it);
  endtask

  task automatic add_query(input int sx, input int sy, input int tx, input int ty,
                           input int gap, input bit drain);
    pending_t it;
    it.cmd = gbns_pkg::in_t'($urandom());
    it.cmd.op = gbns_pkg::OP_QUERY;
    it.cmd.start_x = 5'(sx);
    it.cmd.start_y = 5'(sy);
    it.cmd.target_x = 5'(tx);
    it.cmd.target_y = 5'(ty);
    it.gap = gap;
    it.drain = drain;
    pending.push_back(it);
  endtask

  function automatic int near(input int v);
    int r;
    r = v + $urandom_range(0, 12) - 6;
    return r < 0 ? 0 : (r > DIM - 1 ? DIM - 1 : r);
  endfunction

  initial begin
    int k, kind, sx, sy, tx, ty;
    // Directed: corners, equal and adjacent targets, boxed-in start, blocked target
    add_write(0, 0, 1, 0);
    add_write(31, 31, 1, 0);
    add_write(31, 31, 0, 1);
    add_query(5, 5, 5, 5, 0, 0);
    add_query(10, 10, 11, 10, 0, 0);
    add_write(21, 20, 1, 0);
    add_write(20, 21, 1, 0);
    add_write(19, 20, 1, 0);
    add_write(20, 19, 1, 0);
    add_query(20, 20, 20, 20, 2, 0);
    add_query(20, 20, 25, 25, 0, 0);
    add_write(3, 3, 1, 0);
    add_query(0, 5, 3, 3, 0, 0);
    add_query(0, 31, 31, 0, 0, 1);
    add_query(31, 0, 31, 2, 0, 0);
    add_query(0, 0, 2, 0, 0, 0);
    add_query(31, 31, 30, 31, 0, 0);
    add_query(15, 15, 15, 16, 0, 0);
    add_write(17, 15, 1, 0);
    add_query(16, 15, 18, 15, 0, 0);
    // Random: mostly nearby queries over a grid that fills up, some far ones
    for (k = 0; k < 120; k++) begin
      kind = $urandom_range(0, 99);
      sx = $urandom_range(0, DIM - 1);
      sy = $urandom_range(0, DIM - 1);
      if (kind < 42) begin
        add_write(sx, sy, $urandom_range(0, 1), pick_gap());
      end else if (kind < 82) begin
        add_query(sx, sy, near(sx), near(sy), pick_gap(), k == 0 || $urandom_range(0, 15) == 0);
      end else if (kind < 92) begin
        tx = $urandom_range(0, DIM - 1);
        ty = $urandom_range(0, DIM - 1);
        add_query(sx, sy, tx, ty, pick_gap(), 1'b0);
      end else begin
        // Block the target, then ask for it
        tx = near(sx);
        ty = near(sy);
        add_write(tx, ty, 1, pick_gap());
        add_query(sx, sy, tx, ty, pick_gap(), 1'b0);
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || start || next_steps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (next_steps.size() != 0) errors++;
    $display("covered %0d cell writes and %0d queries", n_writes, n_queries);
    $display("status mix: path %0d, adjacent %0d, no free %0d, unreachable %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gbns_pkg.sv
rtl/gbns_cellmem.sv
rtl/gbns_queue.sv
rtl/grid_bfs_next_step_unit.sv
rtl/gbns_check.sv
tb/grid_bfs_next_step_unit_tb.sv
